// ===== rtl/core/dbdf_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the box decode filter.
`timescale 1ns / 1ps

package dbdf_pkg;

    // Register indices on the configuration port
    localparam logic [7:0] CFG_NET_MODE        = 8'd0;
    localparam logic [7:0] CFG_CLS_NUM         = 8'd1;
    localparam logic [7:0] CFG_MIN_SCORE       = 8'd2;
    localparam logic [7:0] CFG_IMG_W           = 8'd3;
    localparam logic [7:0] CFG_IMG_H           = 8'd4;

    // Network output modes
    localparam logic [1:0] NET_MODE_OBJ    = 2'd0;
    localparam logic [1:0] NET_MODE_CORNER = 2'd1;
    localparam logic [1:0] NET_MODE_SCALED = 2'd2;

    localparam logic [1:0]        RST_NET_MODE        = NET_MODE_CORNER;
    localparam logic [7:0]        RST_CLS_NUM         = 8'd80;
    localparam logic signed [15:0] RST_MIN_SCORE      = 16'sd1024;
    localparam logic [13:0]       RST_IMG_W           = 14'd640;
    localparam logic [13:0]       RST_IMG_H           = 14'd640;

    localparam logic signed [15:0] SCORE_FLOOR = 16'sh8000;
    localparam int CLASS_W = 10;
    localparam int NUM_W   = 34;
    localparam int PROD_W  = 50;

    typedef struct packed {
        logic                frame_start;
        logic signed [31:0]  coord_a;
        logic signed [31:0]  coord_b;
        logic signed [31:0]  coord_c;
        logic signed [31:0]  coord_d;
        logic signed [15:0]  objectness;
        logic signed [15:0]  class_score;
    } t_in_word;

    typedef struct packed {
        logic [6:0]          class_id;
        logic signed [15:0]  score;
        logic signed [31:0]  x_min;
        logic signed [31:0]  y_min;
        logic signed [31:0]  x_max;
        logic signed [31:0]  y_max;
        logic [9:0]          candidate_index;
        logic                list_full;
    } t_out_word;

    typedef struct packed {
        logic [1:0]          net_mode;
        logic [7:0]          cls_num;
        logic signed [15:0]  min_score;
        logic [13:0]         img_w;
        logic [13:0]         img_h;
    } t_cfg;

    // One finished box on its way to the filter stage
    typedef struct packed {
        logic                      clr_count;
        logic [CLASS_W-1:0]        class_id;
        logic signed [15:0]        best_score;
        logic signed [15:0]        objectness;
        logic signed [31:0]        coord_a;
        logic signed [31:0]        coord_b;
        logic signed [31:0]        coord_c;
        logic signed [31:0]        coord_d;
        logic signed [NUM_W-1:0]   num_x_lo;
        logic signed [NUM_W-1:0]   num_y_lo;
        logic signed [NUM_W-1:0]   num_x_hi;
        logic signed [NUM_W-1:0]   num_y_hi;
    } t_box;

    function automatic logic signed [NUM_W-1:0] sx_num(input logic signed [31:0] v);
        sx_num = {{(NUM_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic all_same;
        all_same = (&v[PROD_W-1:31]) | ~(|v[PROD_W-1:31]);
        if (all_same) begin
            sat32 = v[31:0];
        end else if (v[PROD_W-1]) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = 32'sh7FFF_FFFF;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic all_same;
        all_same = (&v[31:15]) | ~(|v[31:15]);
        if (all_same) begin
            sat16 = v[15:0];
        end else if (v[31]) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = 16'sh7FFF;
        end
    endfunction

endpackage

// ===== rtl/core/dbdf_argmax.sv =====
// Class stream front end: argmax over the scores of a box and the box register.
`timescale 1ns / 1ps

module dbdf_argmax #(
    parameter int MAX_CLASSES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dbdf_pkg::t_cfg   i_cfg,
    input  logic             i_in_valid,
    input  dbdf_pkg::t_in_word i_in_word,
    output logic             o_in_stall,
    output logic             o_box_valid,
    output dbdf_pkg::t_box   o_box,
    input  logic             i_box_take
);
    import dbdf_pkg::*;

    localparam int PW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CLOG = $clog2(MAX_CLASSES + 1);
    localparam int NW   = (CLOG > 8) ? CLOG : 8;

    logic [PW-1:0]       r_pos, n_pos;
    logic signed [15:0]  r_best, n_best;
    logic [PW-1:0]       r_cls, n_cls;
    logic signed [31:0]  r_ca, r_cb, r_cc, r_cd;
    logic signed [31:0]  n_ca, n_cb, n_cc, n_cd;
    logic signed [15:0]  r_obj, n_obj;
    logic                r_clr_pend;
    logic                r_box_valid;
    t_box                r_box, n_box;

    logic [NW-1:0]       cls_n;
    logic [PW-1:0]       pos_cur;
    logic                first;
    logic                last;
    logic                clr_eff;
    logic                accept;
    logic signed [15:0]  cur_best;
    logic [PW-1:0]       cur_cls;

    assign o_in_stall = r_box_valid && !i_box_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        // clamp the class count to one..MAX_CLASSES
        if (i_cfg.cls_num == 8'd0) begin
            cls_n = NW'(1);
        end else if (NW'(i_cfg.cls_num) > NW'(MAX_CLASSES)) begin
            cls_n = NW'(MAX_CLASSES);
        end else begin
            cls_n = NW'(i_cfg.cls_num);
        end

        pos_cur = i_in_word.frame_start ? '0 : r_pos;
        if (NW'(pos_cur) >= cls_n) begin
            pos_cur = '0;
        end
        first = (pos_cur == '0);
        last  = (NW'(pos_cur) + NW'(1)) >= cls_n;

        cur_best = first ? SCORE_FLOOR : r_best;
        cur_cls  = first ? '0 : r_cls;
        if (i_in_word.class_score > cur_best) begin
            n_best = i_in_word.class_score;
            n_cls  = pos_cur;
        end else begin
            n_best = cur_best;
            n_cls  = cur_cls;
        end

        n_ca  = first ? i_in_word.coord_a    : r_ca;
        n_cb  = first ? i_in_word.coord_b    : r_cb;
        n_cc  = first ? i_in_word.coord_c    : r_cc;
        n_cd  = first ? i_in_word.coord_d    : r_cd;
        n_obj = first ? i_in_word.objectness : r_obj;

        n_pos   = last ? '0 : PW'(NW'(pos_cur) + NW'(1));
        clr_eff = r_clr_pend | i_in_word.frame_start;

        n_box.clr_count  = clr_eff;
        n_box.class_id   = CLASS_W'(n_cls);
        n_box.best_score = n_best;
        n_box.objectness = n_obj;
        n_box.coord_a    = n_ca;
        n_box.coord_b    = n_cb;
        n_box.coord_c    = n_cc;
        n_box.coord_d    = n_cd;
        n_box.num_x_lo   = (sx_num(n_ca) <<< 1) - sx_num(n_cc);
        n_box.num_y_lo   = (sx_num(n_cb) <<< 1) - sx_num(n_cd);
        n_box.num_x_hi   = (sx_num(n_ca) <<< 1) + sx_num(n_cc);
        n_box.num_y_hi   = (sx_num(n_cb) <<< 1) + sx_num(n_cd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_best      <= SCORE_FLOOR;
            r_cls       <= '0;
            r_clr_pend  <= 1'b0;
            r_box_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos      <= n_pos;
                r_best     <= n_best;
                r_cls      <= n_cls;
                // carry a frame start forward until a box takes it along
                r_clr_pend <= last ? 1'b0 : clr_eff;
            end
            if (accept && last) begin
                r_box_valid <= 1'b1;
            end else if (i_box_take) begin
                r_box_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ca  <= n_ca;
            r_cb  <= n_cb;
            r_cc  <= n_cc;
            r_cd  <= n_cd;
            r_obj <= n_obj;
        end
        if (accept && last) begin
            r_box <= n_box;
        end
    end

    assign o_box_valid = r_box_valid;
    assign o_box       = r_box;

endmodule

// ===== rtl/core/dbdf_box_eval.sv =====
// Box filter stage: mode rules, scaling, threshold, candidate count, result register.
`timescale 1ns / 1ps

module dbdf_box_eval #(
    parameter int MAX_CANDIDATES = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dbdf_pkg::t_cfg    i_cfg,
    input  logic              i_box_valid,
    input  dbdf_pkg::t_box    i_box,
    output logic              o_box_take,
    output logic              o_out_valid,
    output dbdf_pkg::t_out_word o_out_word,
    input  logic              i_out_stall
);
    import dbdf_pkg::*;

    localparam int AW = $clog2(MAX_CANDIDATES + 1);

    logic [AW-1:0]          r_count, n_count;
    logic                   r_out_valid;
    t_out_word              r_out_word, n_out_word;

    logic                   out_free;
    logic [AW-1:0]          count_eff;
    logic signed [15:0]     scale_x, scale_y;
    logic signed [PROD_W-1:0] p_x_lo, p_y_lo, p_x_hi, p_y_hi;
    logic signed [31:0]     p_obj;
    logic signed [31:0]     q_obj;
    logic signed [15:0]     sc;
    logic                   pass_score;
    logic                   emit;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_box_take = i_box_valid && out_free;

    always_comb begin
        if (i_cfg.net_mode == NET_MODE_SCALED) begin
            scale_x = {2'b00, i_cfg.img_w};
            scale_y = {2'b00, i_cfg.img_h};
        end else begin
            scale_x = 16'sd1;
            scale_y = 16'sd1;
        end
        p_x_lo = i_box.num_x_lo * scale_x;
        p_y_lo = i_box.num_y_lo * scale_y;
        p_x_hi = i_box.num_x_hi * scale_x;
        p_y_hi = i_box.num_y_hi * scale_y;

        p_obj = i_box.objectness * i_box.best_score;
        q_obj = p_obj >>> 12;

        n_out_word.class_id = 7'(i_box.class_id);
        unique case (i_cfg.net_mode)
            NET_MODE_OBJ: begin
                sc         = sat16(q_obj);
                pass_score = (i_box.objectness >= i_cfg.min_score)
                             && (sc >= i_cfg.min_score);
            end
            NET_MODE_CORNER, NET_MODE_SCALED: begin
                sc         = i_box.best_score;
                pass_score = sc >= i_cfg.min_score;
            end
            default: begin
                sc         = i_box.best_score;
                pass_score = 1'b0;
            end
        endcase
        n_out_word.score = sc;

        if (i_cfg.net_mode == NET_MODE_CORNER) begin
            n_out_word.x_min = i_box.coord_a;
            n_out_word.y_min = i_box.coord_b;
            n_out_word.x_max = i_box.coord_c;
            n_out_word.y_max = i_box.coord_d;
        end else begin
            // halve with floor, then clip to 32 bits
            n_out_word.x_min = sat32(p_x_lo >>> 1);
            n_out_word.y_min = sat32(p_y_lo >>> 1);
            n_out_word.x_max = sat32(p_x_hi >>> 1);
            n_out_word.y_max = sat32(p_y_hi >>> 1);
        end

        count_eff = i_box.clr_count ? '0 : r_count;
        emit      = pass_score && (count_eff < AW'(MAX_CANDIDATES));
        n_count   = emit ? (count_eff + AW'(1)) : count_eff;

        n_out_word.candidate_index = 10'(count_eff);
        n_out_word.list_full       = (n_count == AW'(MAX_CANDIDATES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_box_take) begin
                r_count <= n_count;
            end
            if (out_free) begin
                r_out_valid <= o_box_take && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_box_take && emit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/detection_box_decode_filter.sv =====
// Two register stages, the box register and then the result register, lie between the
// last class score word of a box and its result.
// Throughput: one class score word per cycle while o_in_stall is low; the argmax update is a single compare.
// The box register and the result register let scores keep flowing while a result waits.
// Reset (synchronous, active low): configuration registers return to their defaults, the class position,
// the argmax and the candidate count clear, and no result is pending.
`timescale 1ns / 1ps

module detection_box_decode_filter #(
    parameter int MAX_CANDIDATES = 1024,
    parameter int MAX_CLASSES    = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    input  dbdf_pkg::t_in_word  i_in_word,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dbdf_pkg::t_out_word o_out_word,
    input  logic                i_out_stall
);
    import dbdf_pkg::*;

    t_cfg   r_cfg;
    logic   box_valid;
    t_box   box;
    logic   box_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.net_mode        <= RST_NET_MODE;
            r_cfg.cls_num         <= RST_CLS_NUM;
            r_cfg.min_score       <= RST_MIN_SCORE;
            r_cfg.img_w           <= RST_IMG_W;
            r_cfg.img_h           <= RST_IMG_H;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_NET_MODE:        r_cfg.net_mode        <= i_cfg_data[1:0];
                CFG_CLS_NUM:         r_cfg.cls_num         <= i_cfg_data[7:0];
                CFG_MIN_SCORE:       r_cfg.min_score       <= i_cfg_data;
                CFG_IMG_W:           r_cfg.img_w           <= i_cfg_data[13:0];
                CFG_IMG_H:           r_cfg.img_h           <= i_cfg_data[13:0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    dbdf_argmax #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_argmax (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_box_valid (box_valid),
        .o_box       (box),
        .i_box_take  (box_take)
    );

    dbdf_box_eval #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_box_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_box_valid (box_valid),
        .i_box       (box),
        .o_box_take  (box_take),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTH
    // input holds off only while a finished box waits for the filter stage
    a_stall_needs_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> box_valid)
        else $error("input stalled with no box pending");

    // a box is only taken from a full box register
    a_take_needs_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        box_take |-> box_valid)
        else $error("box taken from an empty box register");

    // the box that fills the list carries the last candidate index
    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.list_full)
            |-> (o_out_word.candidate_index == 10'(MAX_CANDIDATES - 1)))
        else $error("list full flagged on wrong candidate index");
`endif

endmodule
